FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL files; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define STID_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define STID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/stid_pkg.sv
// Package: sizes, record type, codes and sequencer states of the sorted table.
package stid_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 64;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int IN_KEY_W = 32;
  localparam int IN_PAY_W = 64;
  localparam int IN_IDX_W = 4;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_SHIFT
  } state_t;

endpackage

FILE: rtl/core/stid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sorted_table_insert_delete.sv
// Top level: sorted record table with insert and delete over one RAM and one key comparator.
//
// Records live in a 16-entry RAM kept in ascending key order; a small sequencer walks it
// one entry per cycle through the single read port, one key comparator and the single
// write port. An insert walks down from the top, moving each larger entry up one slot;
// an insert into a full table, or into an empty one, finishes without a walk. A delete
// moves the later entries down; a bad index finishes without a walk. busy is high while
// a walk runs. out_valid pulses for one cycle in the cycle after the item finishes, with
// status, position and the new count; the receiver cannot stall, so take the result in
// that cycle. A new item may be started in that same cycle.
`include "assert_macros.svh"

module sorted_table_insert_delete (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [stid_pkg::IN_KEY_W-1:0]   in_new_key,
  input  logic [stid_pkg::IN_PAY_W-1:0]   in_new_payload,
  input  logic [stid_pkg::IN_IDX_W-1:0]   in_delete_index,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [stid_pkg::POS_W-1:0]      out_position,
  output logic [stid_pkg::COUNT_W-1:0]    out_entry_count
);

  localparam int IDX_W = stid_pkg::IDX_W;
  localparam int CNT_W = stid_pkg::CNT_W;

  stid_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] del_pos_r, del_pos_nxt;
  logic [stid_pkg::KEY_BITS-1:0]     key_r, key_nxt;
  logic [stid_pkg::PAYLOAD_BITS-1:0] pay_r, pay_nxt;

  logic              out_valid_r;
  stid_pkg::status_t out_status_r;
  logic [IDX_W-1:0]  out_pos_r;

  logic              done;
  stid_pkg::status_t done_status;
  logic [IDX_W-1:0]  done_pos;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  stid_pkg::rec_t    ram_wdata;
  stid_pkg::rec_t    rd_rec;
  stid_pkg::rec_t    in_rec;
  stid_pkg::rec_t    held_rec;

  logic              accept;
  logic              key_gt;
  logic [IDX_W-1:0]  del_idx;

  stid_ram #(
    .WIDTH (stid_pkg::REC_W),
    .DEPTH (stid_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_rec)
  );

  assign busy    = (state_r != stid_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign in_rec  = '{key:     in_new_key[stid_pkg::KEY_BITS-1:0],
                     payload: in_new_payload[stid_pkg::PAYLOAD_BITS-1:0]};
  assign held_rec = '{key: key_r, payload: pay_r};
  assign key_gt  = (rd_rec.key > key_r);
  assign del_idx = IDX_W'(in_delete_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stid_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    del_pos_r <= del_pos_nxt;
    key_r     <= key_nxt;
    pay_r     <= pay_nxt;
    if (done) begin
      out_status_r <= done_status;
      out_pos_r    <= done_pos;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    j_nxt       = j_r;
    del_pos_nxt = del_pos_r;
    key_nxt     = key_r;
    pay_nxt     = pay_r;
    done        = 1'b0;
    done_status = stid_pkg::ST_OK;
    done_pos    = j_r;
    ram_we      = 1'b0;
    ram_waddr   = j_r;
    ram_wdata   = held_rec;
    ram_raddr   = '0;

    unique case (state_r)
      stid_pkg::S_IDLE: begin
        if (accept) begin
          key_nxt = in_rec.key;
          pay_nxt = in_rec.payload;
          if (stid_pkg::opcode_t'(in_opcode) == stid_pkg::OP_INSERT) begin
            if (count_r == CNT_W'(stid_pkg::TABLE_DEPTH)) begin
              done        = 1'b1;
              done_status = stid_pkg::ST_FULL;
              done_pos    = '0;
            end else if (count_r == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_rec;
              count_nxt = count_r + 1'b1;
              done      = 1'b1;
              done_pos  = '0;
            end else begin
              j_nxt     = IDX_W'(count_r);
              ram_raddr = IDX_W'(count_r - 1'b1);
              state_nxt = stid_pkg::S_INS_SHIFT;
            end
          end else begin
            if (32'(in_delete_index) >= 32'(count_r)) begin
              done        = 1'b1;
              done_status = stid_pkg::ST_BAD_INDEX;
              done_pos    = '0;
            end else if (32'(in_delete_index) + 32'd1 == 32'(count_r)) begin
              count_nxt = count_r - 1'b1;
              done      = 1'b1;
              done_pos  = del_idx;
            end else begin
              j_nxt       = del_idx;
              del_pos_nxt = del_idx;
              ram_raddr   = del_idx + 1'b1;
              state_nxt   = stid_pkg::S_DEL_SHIFT;
            end
          end
        end
      end

      stid_pkg::S_INS_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        if (key_gt) begin
          ram_wdata = rd_rec;
          j_nxt     = j_r - 1'b1;
          if (j_r == IDX_W'(1)) begin
            state_nxt = stid_pkg::S_INS_PUT;
          end else begin
            ram_raddr = j_r - IDX_W'(2);
          end
        end else begin
          ram_wdata = held_rec;
          count_nxt = count_r + 1'b1;
          done      = 1'b1;
          done_pos  = j_r;
          state_nxt = stid_pkg::S_IDLE;
        end
      end

      stid_pkg::S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = held_rec;
        count_nxt = count_r + 1'b1;
        done      = 1'b1;
        done_pos  = j_r;
        state_nxt = stid_pkg::S_IDLE;
      end

      stid_pkg::S_DEL_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = rd_rec;
        j_nxt     = j_r + 1'b1;
        if (CNT_W'(j_r) + CNT_W'(2) == count_r) begin
          count_nxt = count_r - 1'b1;
          done      = 1'b1;
          done_pos  = del_pos_r;
          state_nxt = stid_pkg::S_IDLE;
        end else begin
          ram_raddr = j_r + IDX_W'(2);
        end
      end

      default: begin
        state_nxt = stid_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = stid_pkg::POS_W'(out_pos_r);
  assign out_entry_count = stid_pkg::COUNT_W'(count_r);

  `STID_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(stid_pkg::TABLE_DEPTH), "count over depth")
  `STID_ASSERT_IMPL(a_result_idle, out_valid_r, !busy, "result while walking")
  `STID_ASSERT_IMPL(a_full_count, out_valid_r && (out_status_r == stid_pkg::ST_FULL), count_r == CNT_W'(stid_pkg::TABLE_DEPTH), "full status below depth")
  `STID_ASSERT_NEXT(a_accept_acts, accept, busy || out_valid_r, "item accepted without effect")

endmodule
